FILE: sv/sps_pkg.sv
package sps_pkg;

  // Field widths of the frame descriptor and the record word.
  localparam int unsigned SampleW  = 36;
  localparam int unsigned OffsetW  = 48;
  localparam int unsigned CountW   = 16;
  localparam int unsigned IndexW   = 20;
  localparam int unsigned StepW    = 36;
  localparam int unsigned TargetW  = 40;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 5;

  // Record layout: 64-bit sample, 64-bit offset, 16-bit count, big-endian.
  localparam int unsigned FieldW   = 64;
  localparam int unsigned RecBytes = 18;
  localparam int unsigned RecW     = RecBytes * ByteW;
  localparam logic [PosW-1:0] RecLast = PosW'(RecBytes - 1);

  // Configuration port.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 36;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeekStep   = 4'd0,
    CfgPointCount = 4'd1
  } cfg_reg_e;

  // Queue between the selector and the serializer.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [OffsetW-1:0] offset;
    logic [CountW-1:0]  count;
    logic [IndexW-1:0]  index;
  } seek_point_t;

  // Handshake between a producer and a consumer of seek points.
  typedef struct packed {
    logic        valid;
    seek_point_t point;
  } point_push_t;

endpackage

FILE: sv/sps_if.sv
interface sps_frame_if;
  import sps_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] frame_first_sample;
  logic [OffsetW-1:0] frame_byte_offset;
  logic [CountW-1:0]  frame_samples;

  modport source (output valid, frame_first_sample, frame_byte_offset, frame_samples,
                  input ready);
  modport sink   (input valid, frame_first_sample, frame_byte_offset, frame_samples,
                  output ready);
endinterface

interface sps_byte_if;
  import sps_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  out_byte;
  logic [PosW-1:0]   byte_position;
  logic [IndexW-1:0] point_index;
  logic              last_byte;

  modport source (output valid, out_byte, byte_position, point_index, last_byte,
                  input ready);
  modport sink   (input valid, out_byte, byte_position, point_index, last_byte,
                  output ready);
endinterface

interface sps_cfg_if;
  import sps_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/sps_front.sv
module sps_front import sps_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sps_cfg_if.sink       cfg_i,
  sps_frame_if.sink     frame_i,
  input  logic          push_ready_i,
  output point_push_t   push_o
);

  logic [StepW-1:0]   seek_step_q;
  logic [IndexW-1:0]  point_count_q;
  logic [IndexW-1:0]  emitted_q, emitted_d;
  logic [TargetW-1:0] target_q, target_d;
  logic               first_seen_q, first_seen_d;

  logic               accept;
  logic               chosen;
  logic [TargetW:0]   target_sum;

  assign cfg_i.ready   = 1'b1;
  assign frame_i.ready = push_ready_i;
  assign accept        = frame_i.valid && frame_i.ready;

  // A frame is chosen once the first frame has passed, while slots remain and
  // its first sample has reached the target.
  assign chosen = first_seen_q && (emitted_q < point_count_q) &&
                  ({{(TargetW-SampleW){1'b0}}, frame_i.frame_first_sample} >= target_q);

  assign target_sum = {1'b0, target_q} + {{(TargetW+1-StepW){1'b0}}, seek_step_q};

  always_comb begin
    emitted_d    = emitted_q;
    target_d     = target_q;
    first_seen_d = first_seen_q;
    if (accept) begin
      if (!first_seen_q) begin
        first_seen_d = 1'b1;
        target_d     = {{(TargetW-StepW){1'b0}}, seek_step_q};
      end else if (chosen) begin
        emitted_d = emitted_q + IndexW'(1);
        // The target saturates; a saturated target is beyond every sample.
        target_d  = target_sum[TargetW] ? {TargetW{1'b1}} : target_sum[TargetW-1:0];
      end
    end
  end

  always_comb begin
    push_o.valid        = accept && chosen;
    push_o.point.sample = frame_i.frame_first_sample;
    push_o.point.offset = frame_i.frame_byte_offset;
    push_o.point.count  = frame_i.frame_samples;
    push_o.point.index  = emitted_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seek_step_q   <= '0;
      point_count_q <= '0;
      emitted_q     <= '0;
      target_q      <= '0;
      first_seen_q  <= 1'b0;
    end else begin
      emitted_q    <= emitted_d;
      target_q     <= target_d;
      first_seen_q <= first_seen_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CfgSeekStep:   seek_step_q   <= cfg_i.data[StepW-1:0];
          CfgPointCount: point_count_q <= cfg_i.data[IndexW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sv/sps_queue.sv
module sps_queue import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  point_push_t push_i,
  output logic        push_ready_o,
  output point_push_t pop_o,
  input  logic        pop_ready_i
);

  seek_point_t       mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCntW'(QDepth));
  assign do_push      = push_i.valid && push_ready_o;
  assign pop_o.valid  = (count_q != '0);
  assign pop_o.point  = mem_q[rd_ptr_q];
  assign do_pop       = pop_o.valid && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.point;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCntW'(1);
        2'b01:   count_q <= count_q - QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: sv/sps_back.sv
module sps_back import sps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  point_push_t pop_i,
  output logic        pop_ready_o,
  sps_byte_if.source  rec_o
);

  logic              busy_q;
  logic [PosW-1:0]   pos_q;
  logic [RecW-1:0]   rec_q;
  logic [IndexW-1:0] idx_q;
  logic              fire, last, do_pop;

  assign fire        = rec_o.valid && rec_o.ready;
  assign last        = (pos_q == RecLast);
  assign pop_ready_o = !busy_q || (fire && last);
  assign do_pop      = pop_i.valid && pop_ready_o;

  assign rec_o.valid         = busy_q;
  assign rec_o.out_byte      = rec_q[RecW-1 -: ByteW];
  assign rec_o.byte_position = pos_q;
  assign rec_o.point_index   = idx_q;
  assign rec_o.last_byte     = last;

  // The record sits in a shift register, most significant byte first.
  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      rec_q <= {{(FieldW-SampleW){1'b0}}, pop_i.point.sample,
                {(FieldW-OffsetW){1'b0}}, pop_i.point.offset,
                pop_i.point.count};
      idx_q <= pop_i.point.index;
    end else if (fire) begin
      rec_q <= {rec_q[RecW-ByteW-1:0], {ByteW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      if (do_pop) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (fire) begin
        if (last) begin
          busy_q <= 1'b0;
        end
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

endmodule

FILE: sv/seek_point_selector_unit.sv
// Channel   Dir  Handshake      Word
// cfg_i     in   valid/ready    index (0 seek step, 1 point count), data
// frame_i   in   valid/ready    first sample, byte offset, sample count of one frame
// rec_o     out  valid/ready    one record byte with its position, slot index, last flag
//
// A frame is accepted in any cycle in which the two-entry queue has room, so frames
// that are not chosen pass at one per cycle. Each chosen frame becomes 18 words, one
// per cycle from the byte serializer while rec_o is ready; that serializer sets the
// sustained rate, and consecutive records follow each other with no gap.
// Reset is asynchronous and active low; it clears the registers, the selection
// state and the queue. A stall on rec_o holds the current word and, once the queue
// is full, holds frame_i ready low; configuration writes are always taken.
module seek_point_selector_unit import sps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sps_cfg_if.sink    cfg_i,
  sps_frame_if.sink  frame_i,
  sps_byte_if.source rec_o
);

  // Front: decides per frame whether it becomes a seek point and tracks the
  // emitted count and the next target sample.
  point_push_t push;
  logic        push_ready;

  // Back: serializes queued seek points into big-endian record bytes.
  point_push_t pop;
  logic        pop_ready;

  sps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .frame_i      (frame_i),
    .push_ready_i (push_ready),
    .push_o       (push)
  );

  // The queue decouples selection from serialization, so new frames are taken
  // while a record is still being sent.
  sps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready)
  );

  sps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_i       (pop),
    .pop_ready_o (pop_ready),
    .rec_o       (rec_o)
  );

endmodule

FILE: sv/sps_checker.sv
module sps_port_checker import sps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              ready_i,
  input logic [ByteW-1:0]  out_byte_i,
  input logic [PosW-1:0]   byte_position_i,
  input logic [IndexW-1:0] point_index_i,
  input logic              last_byte_i
);

  logic fire;
  assign fire = valid_i && ready_i;

  // A stalled word stays offered and unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(out_byte_i) && $stable(byte_position_i))
    else $error("record word changed while stalled");

  // The last flag marks exactly the final byte position.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (last_byte_i == (byte_position_i == RecLast)))
    else $error("last_byte does not match byte_position");

  // Within a record the bytes come in order, without gaps, for the same slot.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last_byte_i |=> valid_i &&
      byte_position_i == $past(byte_position_i) + PosW'(1) &&
      point_index_i == $past(point_index_i))
    else $error("record bytes out of order");

  // After the final byte, the next word begins a new record.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_byte_i |=> !valid_i || byte_position_i == '0)
    else $error("record did not start at position zero");

endmodule

bind seek_point_selector_unit sps_port_checker u_sps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (rec_o.valid),
  .ready_i         (rec_o.ready),
  .out_byte_i      (rec_o.out_byte),
  .byte_position_i (rec_o.byte_position),
  .point_index_i   (rec_o.point_index),
  .last_byte_i     (rec_o.last_byte)
);
